// ----- rtl/core/ffba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int ADDR_W  = 20;
    localparam int SIZE_W  = 21;
    // header plus largest request plus alignment slack
    localparam int TOTAL_W = 22;

    localparam logic [SIZE_W-1:0] LIMIT_CAP = 21'h100000;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_REUSED   = 3'd0,
        ST_EXTENDED = 3'd1,
        ST_NO_SPACE = 3'd2,
        ST_ZERO     = 3'd3,
        ST_FREED    = 3'd4,
        ST_DOUBLE   = 3'd5,
        ST_UNKNOWN  = 3'd6
    } status_t;

    typedef struct packed {
        logic              opcode;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] data_address;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] bytes;
        logic              free;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

// ----- rtl/core/first_fit_block_allocator.sv -----
`timescale 1ns / 1ps
// An allocate rounds its size, then reads table entries in order up to the reused entry k
//   or through all N to extend or fail; a free reads up to the matching entry or through all
//   N. N is entry_count; zero-size and null requests skip the scan. One request at a time,
//   the next taken the cycle after the response is loaded; a held response stalls.
// Reset clears entry count, heap top and handshake state; the limit register returns to 1048576.
//   Table contents are not cleared: entries at or above the count are never read.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator over an address-ordered block table in RAM.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 32,
    parameter int ALIGN_BYTES  = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  ffba_pkg::req_t              req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output ffba_pkg::rsp_t              rsp,
    input  logic                        cfg_we,
    input  logic [ffba_pkg::SIZE_W-1:0] cfg_wdata
);
    import ffba_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [SIZE_W-1:0] HDR = SIZE_W'(HEADER_BYTES);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);

    state_t             state_reg, state_next;
    logic               op_reg, op_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [CW-1:0]      scan_idx_reg, scan_idx_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [IW-1:0]      chk_idx_reg, chk_idx_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [SIZE_W-1:0]  top_reg, top_next;
    logic [SIZE_W-1:0]  limit_reg;
    rsp_t               res_reg, res_next;
    rsp_t               out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               align_start;
    logic               align_done;
    logic [TOTAL_W-1:0] total;

    logic               rd_en;
    entry_t             rd_data;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    entry_t             wr_data;

    logic               issuing;
    logic               alloc_hit;
    logic               free_hit;
    logic               hit;
    logic [SIZE_W-1:0]  limit_eff;
    logic [TOTAL_W:0]   grown;

    ffba_align #(
        .ALIGN_BYTES(ALIGN_BYTES)
    ) u_align (
        .clk  (clk),
        .rst_n(rst_n),
        .start(align_start),
        .value(TOTAL_W'(req.request_size) + TOTAL_W'(HEADER_BYTES)),
        .done (align_done),
        .total(total)
    );

    ffba_table #(
        .DEPTH(MAX_BLOCKS)
    ) u_table (
        .clk    (clk),
        .rd_en  (rd_en),
        .rd_addr(scan_idx_reg[IW-1:0]),
        .rd_data(rd_data),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    assign issuing   = scan_idx_reg < count_reg;
    assign alloc_hit = rd_data.free && ({1'b0, rd_data.bytes} >= total);
    assign free_hit  = (({1'b0, rd_data.start} + HDR) == {1'b0, addr_reg});
    assign hit       = (op_reg == OP_ALLOC) ? alloc_hit : free_hit;
    assign limit_eff = (limit_reg > LIMIT_CAP) ? LIMIT_CAP : limit_reg;
    assign grown     = {2'b00, top_reg} + {1'b0, total};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chk_valid_reg <= 1'b0;
            count_reg     <= '0;
            top_reg       <= '0;
            limit_reg     <= LIMIT_CAP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            count_reg     <= count_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        scan_idx_reg <= scan_idx_next;
        chk_idx_reg  <= chk_idx_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        scan_idx_next  = scan_idx_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        align_start    = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = chk_idx_reg;
        wr_data        = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next       = req.opcode;
                    addr_next     = req.block_address;
                    scan_idx_next = '0;
                    res_next      = '{status: ST_UNKNOWN, data_address: '0};
                    if (req.opcode == OP_ALLOC)
                    begin
                        if (req.request_size == '0)
                        begin
                            res_next.status = ST_ZERO;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            // rounding starts on the accepting edge
                            align_start = 1'b1;
                            state_next  = S_ROUND;
                        end
                    end
                    else if (req.block_address == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_ROUND:
            begin
                if (align_done)
                begin
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                priority if (chk_valid_reg && hit)
                begin
                    state_next = S_DONE;
                    if (op_reg == OP_ALLOC)
                    begin
                        wr_en        = 1'b1;
                        wr_data.free = 1'b0;
                        res_next     = '{status: ST_REUSED,
                                         data_address: rd_data.start + HDR[ADDR_W-1:0]};
                    end
                    else if (rd_data.free)
                    begin
                        res_next.status = ST_DOUBLE;
                    end
                    else
                    begin
                        wr_en           = 1'b1;
                        wr_data.free    = 1'b1;
                        res_next.status = ST_FREED;
                    end
                end
                else if (issuing)
                begin
                    rd_en          = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx_reg[IW-1:0];
                    scan_idx_next  = scan_idx_reg + 1'b1;
                end
                else if (!chk_valid_reg)
                begin
                    // every entry checked, none matched
                    state_next = S_DONE;
                    if (op_reg == OP_ALLOC)
                    begin
                        if (count_reg >= MAX_CNT || grown > {2'b00, limit_eff})
                        begin
                            res_next.status = ST_NO_SPACE;
                        end
                        else
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = count_reg[IW-1:0];
                            wr_data.start = top_reg[ADDR_W-1:0];
                            wr_data.bytes = total[SIZE_W-1:0];
                            wr_data.free  = 1'b0;
                            count_next    = count_reg + 1'b1;
                            top_next      = grown[SIZE_W-1:0];
                            res_next      = '{status: ST_EXTENDED,
                                              data_address: top_reg[ADDR_W-1:0]
                                                            + HDR[ADDR_W-1:0]};
                        end
                    end
                end
                else
                begin
                    // last read still in flight
                    state_next = S_SCAN;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ----- rtl/core/ffba_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_table
// Block table: single-port-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module ffba_table #(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output ffba_pkg::entry_t         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  ffba_pkg::entry_t         wr_data
);
    import ffba_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/ffba_align.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_align
// Rounds a byte count up to a multiple of ALIGN_BYTES by reciprocal multiplication;
// start registers the biased value, then the quotient register loads; total is valid from done.
// ----------------------------------------------------------------------------
module ffba_align #(
    parameter int ALIGN_BYTES = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ffba_pkg::TOTAL_W-1:0]   value,
    output logic                           done,
    output logic [ffba_pkg::TOTAL_W-1:0]   total
);
    import ffba_pkg::*;

    // floor(v / ALIGN_BYTES) == (v * RECIP) >> SHIFT for every v below 2**TOTAL_W
    localparam int LOG_A = $clog2(ALIGN_BYTES);
    localparam int SHIFT = TOTAL_W + LOG_A;
    localparam int RW    = TOTAL_W + 1;
    localparam int PW    = TOTAL_W + RW;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
    localparam logic [RW-1:0]      RECIP   = RW'(RECIP_L);
    localparam logic [TOTAL_W-1:0] BIAS    = TOTAL_W'(ALIGN_BYTES - 1);
    localparam logic [TOTAL_W-1:0] ALIGN_V = TOTAL_W'(ALIGN_BYTES);

    logic [TOTAL_W-1:0] biased_reg;
    logic [TOTAL_W-1:0] quot_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [PW-1:0]      product;

    assign product = {{RW{1'b0}}, biased_reg} * {{TOTAL_W{1'b0}}, RECIP};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            biased_reg <= value + BIAS;
        end
        if (busy_reg)
        begin
            quot_reg <= TOTAL_W'(product >> SHIFT);
        end
    end

    assign done  = done_reg;
    assign total = quot_reg * ALIGN_V;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for first_fit_block_allocator. A driver pushes allocate
// and free requests from a queue and a monitor predicts every response from
// its own copy of the block table, then compares status and data address.
// Runs through several heap limits, random idle bursts on both sides, a long
// response hold-off and a calm final stretch.
// ----------------------------------------------------------------------------
module tb;
    import ffba_pkg::*;

    localparam int MAX_BLOCKS   = 64;
    localparam int HDR_BYTES    = 32;
    localparam int ALIGN        = 8;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int LONG_HOLD_AT = 150;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 100;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    req_t              req       = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    rsp_t              rsp;
    logic              cfg_we    = 1'b0;
    logic [SIZE_W-1:0] cfg_wdata = '0;

    // predicted table contents
    int blk_start [MAX_BLOCKS];
    int blk_bytes [MAX_BLOCKS];
    bit blk_free  [MAX_BLOCKS];
    int blk_count   = 0;
    int heap_end    = 0;
    int limit_bytes = int'(LIMIT_CAP);

    req_t pending_reqs [$];
    rsp_t due_rsps [$];
    rsp_t due_rsp;

    int offer_cnt  = 0;
    int accept_cnt = 0;
    int rsp_cnt    = 0;
    int err_cnt    = 0;
    int cycle_cnt  = 0;
    bit calm       = 1'b0;

    int gap_left       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    bit long_hold_done = 1'b0;

    first_fit_block_allocator #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .HEADER_BYTES(HDR_BYTES),
        .ALIGN_BYTES (ALIGN)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // Applies one request to the predicted table and returns the response.
    function automatic rsp_t predict_response(req_t r);
        rsp_t res;
        int   total;
        int   cap;
        int   i;
        bit   found;
        res.status       = ST_UNKNOWN;
        res.data_address = '0;
        found            = 1'b0;
        if (r.opcode == OP_ALLOC) begin
            if (r.request_size == '0) begin
                res.status = ST_ZERO;
            end
            else begin
                total = ((int'(r.request_size) + HDR_BYTES + ALIGN - 1) / ALIGN) * ALIGN;
                for (i = 0; i < blk_count; i++) begin
                    if (!found && blk_free[i] && blk_bytes[i] >= total) begin
                        found            = 1'b1;
                        blk_free[i]      = 1'b0;
                        res.status       = ST_REUSED;
                        res.data_address = ADDR_W'(blk_start[i] + HDR_BYTES);
                    end
                end
                if (!found) begin
                    cap = (limit_bytes > int'(LIMIT_CAP)) ? int'(LIMIT_CAP) : limit_bytes;
                    if (blk_count >= MAX_BLOCKS || heap_end + total > cap) begin
                        res.status = ST_NO_SPACE;
                    end
                    else begin
                        blk_start[blk_count] = heap_end;
                        blk_bytes[blk_count] = total;
                        blk_free[blk_count]  = 1'b0;
                        blk_count++;
                        res.status           = ST_EXTENDED;
                        res.data_address     = ADDR_W'(heap_end + HDR_BYTES);
                        heap_end             = heap_end + total;
                    end
                end
            end
        end
        else if (r.block_address != '0) begin
            for (i = 0; i < blk_count; i++) begin
                if (!found && blk_start[i] + HDR_BYTES == int'(r.block_address)) begin
                    found      = 1'b1;
                    res.status = blk_free[i] ? ST_DOUBLE : ST_FREED;
                    blk_free[i] = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic req_t alloc_req(int size);
        req_t r;
        r.opcode        = OP_ALLOC;
        r.request_size  = SIZE_W'(size);
        r.block_address = ADDR_W'($urandom);
        return r;
    endfunction

    function automatic req_t free_req(int addr);
        req_t r;
        r.opcode        = OP_FREE;
        r.request_size  = SIZE_W'($urandom);
        r.block_address = ADDR_W'(addr);
        return r;
    endfunction

    // Mostly frees of known blocks and modest allocations, with some noise.
    function automatic req_t random_request(int free_pct);
        int pick;
        int idx;
        int size;
        int addr;
        pick = $urandom_range(19, 0);
        if ($urandom_range(99, 0) < free_pct) begin
            addr = $urandom;
            if (pick < 15 && blk_count > 0) begin
                idx  = $urandom_range(blk_count - 1, 0);
                addr = blk_start[idx] + HDR_BYTES;
            end
            else if (pick < 17) begin
                addr = 0;
            end
            else if (pick == 17 && blk_count > 0) begin
                // near miss: ALIGN bytes past a block's data address, itself no data address
                idx  = $urandom_range(blk_count - 1, 0);
                addr = blk_start[idx] + HDR_BYTES + ALIGN;
            end
            return free_req(addr);
        end
        if (pick < 13) begin
            size = $urandom_range(512, 1);
        end
        else if (pick < 16) begin
            size = $urandom_range(8192, 1);
        end
        else if (pick == 16) begin
            size = 0;
        end
        else if (pick == 17) begin
            size = $urandom_range(1 << 18, 1);
        end
        else begin
            size = $urandom;
        end
        return alloc_req(size);
    endfunction

    task automatic offer_request(req_t r);
        do @(posedge clk); while (pending_reqs.size() >= 2);
        pending_reqs.push_back(r);
    endtask

    task automatic offer_random(int count, int free_pct);
        int n;
        for (n = 0; n < count; n++) begin
            offer_request(random_request(free_pct));
        end
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (pending_reqs.size() != 0 || req_valid || offer_cnt != accept_cnt ||
               due_rsps.size() != 0);
    endtask

    task automatic write_limit(logic [SIZE_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // request driver
    always @(negedge clk) begin
        if (rst_n && offer_cnt == accept_cnt) begin
            if (gap_left > 0) begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() == 0) begin
                req_valid <= 1'b0;
            end
            else if (!calm && $urandom_range(4, 0) == 0) begin
                gap_left  = $urandom_range(14, 0);
                req_valid <= 1'b0;
            end
            else begin
                req       <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                offer_cnt++;
            end
        end
    end

    // response ready, with the one long hold-off counted here
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (!long_hold_done && rsp_cnt >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                rsp_ready      <= 1'b0;
            end
            else if (calm) begin
                rsp_ready <= 1'b1;
            end
            else if (stall_left > 0) begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if ($urandom_range(5, 0) == 0) begin
                stall_left = $urandom_range(14, 0);
                rsp_ready  <= 1'b0;
            end
            else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // monitor and checker
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we) begin
                limit_bytes = int'(cfg_wdata);
            end
            if (req_valid && req_ready) begin
                due_rsps.push_back(predict_response(req));
                accept_cnt++;
            end
            if (rsp_valid && rsp_ready) begin
                rsp_cnt++;
                if (due_rsps.size() == 0) begin
                    $display("%0t: response with no request pending: status %0d addr %h",
                             $time, rsp.status, rsp.data_address);
                    err_cnt++;
                end
                else begin
                    due_rsp = due_rsps.pop_front();
                    if (rsp.status !== due_rsp.status) begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, due_rsp.status, rsp.status);
                        err_cnt++;
                    end
                    if (rsp.data_address !== due_rsp.data_address) begin
                        $display("%0t: data_address mismatch: expected %h actual %h",
                                 $time, due_rsp.data_address, rsp.data_address);
                        err_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("first_fit_block_allocator verification failed");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty heap, zero limit
        write_limit('0);
        offer_request(alloc_req(1));
        offer_request(alloc_req(0));
        offer_request(free_req(0));
        offer_request(free_req(20'hFFFFF));
        offer_request(free_req(HDR_BYTES));
        offer_request(alloc_req(1 << 20));
        wait_drained();

        // small heap: reuse, double free, exact fit against the limit
        write_limit(SIZE_W'(4096));
        offer_request(alloc_req(1));
        offer_request(alloc_req(8));
        offer_request(free_req(HDR_BYTES));
        offer_request(free_req(HDR_BYTES));
        offer_request(alloc_req(8));
        offer_request(alloc_req(9));
        offer_request(free_req(72));
        offer_request(alloc_req(1));
        offer_request(alloc_req(4000));
        offer_request(alloc_req(3936));
        offer_request(alloc_req(1));
        offer_random(60, 40);
        wait_drained();

        // full limit: fill the table first, then mixed traffic
        write_limit(LIMIT_CAP);
        offer_random(100, 10);
        offer_random(320, 45);
        wait_drained();

        // limit above range, no idling
        write_limit('1);
        calm = 1'b1;
        offer_random(180, 40);
        offer_request(alloc_req(21'h1FFFFF));
        offer_request(alloc_req(1 << 20));
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0) begin
            $display("first_fit_block_allocator verification clean");
        end
        else begin
            $display("first_fit_block_allocator verification failed");
        end
        $finish;
    end

endmodule
